### src/binary_search_last_occurrence_assert.svh
// Assertion macros shared by the search block modules.
`ifndef BINARY_SEARCH_LAST_OCCURRENCE_ASSERT_SVH
`define BINARY_SEARCH_LAST_OCCURRENCE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsl assertion failed");

// Next-cycle implication, checked out of reset.
`define BSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsl assertion failed");

`endif

### src/bsl_pkg.sv
// Constants and types shared by the last-occurrence search block.
package bsl_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(TABLE_DEPTH);

    // Table write port.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } tbl_wr_t;

    // Table read port.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } tbl_rd_t;

    // Search launch from the command side.
    typedef struct packed {
        logic                     start;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] key;
    } srch_cmd_t;

    // Search engine status and result.
    typedef struct packed {
        logic             idle;
        logic             done;
        logic             found;
        logic [IDX_W-1:0] index;
    } srch_sts_t;

endpackage

### src/bsl_req_if.sv
// Request channel: operation and value beats.
interface bsl_req_if
    import bsl_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

### src/bsl_rsp_if.sv
// Response channel: search result beats.
interface bsl_rsp_if
    import bsl_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] last_index;

    modport source (output valid, output found, output last_index, input ready);
    modport sink   (input valid, input found, input last_index, output ready);
endinterface

### src/bsl_table.sv
// Element table: single-port-write, single-port-read synchronous memory.
module bsl_table
    import bsl_pkg::*;
(
    input  logic              clk,
    input  tbl_wr_t           wr,
    input  tbl_rd_t           rd,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [TABLE_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/bsl_engine.sv
// Binary search sequencer: probes the table and keeps the last match.
`include "binary_search_last_occurrence_assert.svh"

module bsl_engine
    import bsl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  srch_cmd_t         cmd,
    input  logic              take,
    input  logic [DATA_W-1:0] rdata,
    output tbl_rd_t           rd,
    output srch_sts_t         sts
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         end_reg, end_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         mid_reg, mid_next;
    logic [IDX_W-1:0]         where_reg, where_next;
    logic                     hit_reg, hit_next;
    logic signed [DATA_W-1:0] key_reg, key_next;

    logic [CNT_W-1:0]         span;
    logic [CNT_W-1:0]         mid_full;
    logic [CNT_W-1:0]         mid_plus;
    logic signed [DATA_W-1:0] probe;

    // Midpoint of the open window [lo, end): lo + (end - 1 - lo) / 2.
    assign span     = end_reg - lo_reg - CNT_W'(1);
    assign mid_full = lo_reg + (span >> 1);
    assign mid_plus = {1'b0, mid_reg} + CNT_W'(1);
    assign probe    = rdata;

    // Sequencer: each probe passes through a read state and then a compare state.
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        end_next   = end_reg;
        cnt_next   = cnt_reg;
        mid_next   = mid_reg;
        where_next = where_reg;
        hit_next   = hit_reg;
        key_next   = key_reg;
        rd.en      = 1'b0;
        rd.addr    = mid_full[IDX_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    lo_next    = '0;
                    end_next   = cmd.count;
                    cnt_next   = cmd.count;
                    key_next   = cmd.key;
                    hit_next   = 1'b0;
                    where_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (lo_reg < end_reg)
                begin
                    rd.en      = 1'b1;
                    mid_next   = mid_full[IDX_W-1:0];
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                if (probe == key_reg)
                begin
                    hit_next   = 1'b1;
                    where_next = mid_reg;
                    lo_next    = mid_plus;
                end
                else if (probe < key_reg)
                begin
                    lo_next = mid_plus;
                end
                else
                begin
                    end_next = {1'b0, mid_reg};
                end
                state_next = S_READ;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Search window and result.
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        end_reg   <= end_next;
        cnt_reg   <= cnt_next;
        mid_reg   <= mid_next;
        where_reg <= where_next;
        hit_reg   <= hit_next;
        key_reg   <= key_next;
    end

    assign sts.idle  = (state_reg == S_IDLE);
    assign sts.done  = (state_reg == S_DONE);
    assign sts.found = hit_reg;
    assign sts.index = hit_reg ? where_reg : '0;

    // The window never inverts and stays inside the filled part.
    `BSL_ASSERT_NOW(a_window_order, clk, rst_n, state_reg == S_READ, (lo_reg <= end_reg) && (end_reg <= cnt_reg))
    // A compare always follows the read that feeds it.
    `BSL_ASSERT_NOW(a_cmp_after_read, clk, rst_n, state_reg == S_CMP, $past(state_reg == S_READ))
    // A recorded match lies inside the filled part of the table.
    `BSL_ASSERT_NOW(a_hit_in_range, clk, rst_n, (state_reg == S_DONE) && hit_reg, {1'b0, where_reg} < cnt_reg)

endmodule

### src/binary_search_last_occurrence.sv
// Top level of the last-occurrence binary search block.
//
//   Channel  Dir  Payload                      Beat moves when
//   req      in   operation[1:0], value[31:0]  req.valid && req.ready
//   rsp      out  found, last_index[9:0]       rsp.valid && rsp.ready
//
// Clear and append give no beat on rsp.
// A search makes one table read and one compare per probe, after a launch and
// before a hand-off; the registered read port of the element table is why the
// read and the compare of a probe are separate steps.
// Reset clears the element count and the sequencer; table contents are kept.
// One result can wait on a stalled rsp; a second one in the engine blocks req.
`include "binary_search_last_occurrence_assert.svh"

module binary_search_last_occurrence
    import bsl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bsl_req_if.sink    req,
    bsl_rsp_if.source  rsp
);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic              found_reg;
    logic [IDX_W-1:0]  index_reg;

    logic              req_fire;
    logic              take;
    tbl_wr_t           wr;
    tbl_rd_t           rd;
    logic [DATA_W-1:0] rdata;
    srch_cmd_t         cmd;
    srch_sts_t         sts;

    assign req.ready = sts.idle;
    assign req_fire  = req.valid && req.ready;

    // Engine result moves into the output register when the slot frees up.
    assign take = sts.done && (!rsp_valid_reg || rsp.ready);

    // Command decode.
    always_comb
    begin
        count_next = count_reg;
        wr.en      = 1'b0;
        wr.addr    = count_reg[IDX_W-1:0];
        wr.data    = req.value;
        cmd.start  = 1'b0;
        cmd.count  = count_reg;
        cmd.key    = req.value;
        if (req_fire)
        begin
            case (req.operation)
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                OP_APPEND:
                begin
                    if (count_reg < COUNT_FULL)
                    begin
                        wr.en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_SEARCH:
                begin
                    cmd.start = 1'b1;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Output valid flag.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (take)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            found_reg <= sts.found;
            index_reg <= sts.index;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.found      = found_reg;
    assign rsp.last_index = index_reg;

    bsl_table u_table (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    bsl_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .take  (take),
        .rdata (rdata),
        .rd    (rd),
        .sts   (sts)
    );

    // The element count never passes the table depth.
    `BSL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= COUNT_FULL)
    // An accepted search occupies the engine in the next cycle.
    `BSL_ASSERT_NEXT(a_search_busy, clk, rst_n, req_fire && (req.operation == OP_SEARCH), !sts.idle)
    // A not-found result carries a zero index.
    `BSL_ASSERT_NOW(a_miss_zero, clk, rst_n, rsp_valid_reg && !found_reg, index_reg == '0)

endmodule

### tb/sv/binary_search_last_occurrence_test.sv
// Self-checking testbench for the last-occurrence binary search block.
`timescale 1ns / 100ps

module binary_search_last_occurrence_test;
    import bsl_pkg::*;

    // Operation code that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int RANDOM_BEATS = 700;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } req_beat_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] last_index;
    } search_result_t;

    logic clk = 1'b0;
    logic rst_n;

    bsl_req_if req_ch ();
    bsl_rsp_if rsp_ch ();

    binary_search_last_occurrence dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Beats waiting to be sent and search answers waiting to arrive.
    req_beat_t      pending_items[$];
    search_result_t pending_answers[$];

    // Copy of the element table as the block should hold it.
    logic signed [DATA_W-1:0] mirror_elems [TABLE_DEPTH];
    int mirror_count;

    // Values appended in the current run, used to aim search keys.
    logic signed [DATA_W-1:0] phase_vals[$];

    int  stim_count;
    int  error_count;
    int  clears_seen;
    int  appends_seen;
    int  searches_seen;
    int  hits_seen;
    int  deepest_fill;
    int  req_idle_left;
    int  rsp_stall_left;
    bit  req_calm;
    bit  rsp_calm;
    search_result_t want;
    search_result_t answer;

    always #10 clk = ~clk;

    // Binary search as the block runs it: on a match record the probe and go right.
    function automatic search_result_t last_match(input logic signed [DATA_W-1:0] key);
        search_result_t res;
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = mirror_count - 1;
        res = '0;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (mirror_elems[mid] == key) begin
                res.found      = 1'b1;
                res.last_index = mid[IDX_W-1:0];
                lo = mid + 1;
            end
            else if (mirror_elems[mid] < key) begin
                lo = mid + 1;
            end
            else begin
                hi = mid - 1;
            end
        end
        return res;
    endfunction

    // Applies one accepted request beat to the mirror and predicts any answer.
    task automatic apply_beat(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
        case (op)
            OP_CLEAR:
            begin
                mirror_count = 0;
                clears_seen++;
            end
            OP_APPEND:
            begin
                if (mirror_count < TABLE_DEPTH) begin
                    mirror_elems[mirror_count] = value;
                    mirror_count++;
                    if (mirror_count > deepest_fill)
                        deepest_fill = mirror_count;
                end
                appends_seen++;
            end
            OP_SEARCH:
            begin
                pending_answers.push_back(last_match(value));
                searches_seen++;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic queue_beat(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
        req_beat_t b;
        b.op    = op;
        b.value = value;
        pending_items.push_back(b);
        if (op != OP_UNUSED)
            stim_count++;
    endtask

    // Half the keys are present ones; the rest are neighbors, random values and the extremes.
    function automatic logic signed [DATA_W-1:0] pick_key();
        logic signed [DATA_W-1:0] k;
        int sel;
        sel = $urandom_range(0, 5);
        if (phase_vals.size() == 0 || sel == 4)
            k = $urandom;
        else if (sel <= 2)
            k = phase_vals[$urandom_range(0, phase_vals.size() - 1)];
        else if (sel == 3)
            k = phase_vals[$urandom_range(0, phase_vals.size() - 1)]
                + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
        else
            k = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        return k;
    endfunction

    // Clears, then fills an ascending run with duplicates, searching along the way.
    task automatic build_sorted_run(input int n);
        longint v;
        longint step;
        int k;
        queue_beat(OP_CLEAR, $urandom);
        phase_vals.delete();
        case ($urandom_range(0, 2))
            0:       v = longint'($signed($urandom));
            1:       v = longint'(int'($urandom_range(0, 20)) - 10);
            default: v = longint'(VAL_MIN) + longint'($urandom_range(0, 5));
        endcase
        for (k = 0; k < n; k++) begin
            queue_beat(OP_APPEND, v[DATA_W-1:0]);
            phase_vals.push_back(v[DATA_W-1:0]);
            if ($urandom_range(0, 5) == 0)
                queue_beat(OP_SEARCH, pick_key());
            if ($urandom_range(0, 2) == 0)
                step = 0;
            else if ($urandom_range(0, 1) == 0)
                step = longint'($urandom_range(1, 3));
            else
                step = longint'($urandom);
            v = v + step;
            if (v > longint'(VAL_MAX))
                v = longint'(VAL_MAX);
        end
        repeat ($urandom_range(1, 6))
            queue_beat(OP_SEARCH, pick_key());
    endtask

    // Request side: presents beats from the queue with random idle cycles between them.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= OP_CLEAR;
            req_ch.value     <= '0;
            req_idle_left = 0;
        end
        else begin
            if (req_ch.valid && req_ch.ready) begin
                apply_beat(req_ch.operation, req_ch.value);
                if ($urandom_range(0, 49) == 0)
                    req_calm = !req_calm;
                req_idle_left = req_calm ? 0 : $urandom_range(0, 7);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_idle_left > 0 || pending_items.size() == 0) begin
                    if (req_idle_left > 0)
                        req_idle_left--;
                    req_ch.valid <= 1'b0;
                end
                else begin
                    req_ch.valid     <= 1'b1;
                    req_ch.operation <= pending_items[0].op;
                    req_ch.value     <= pending_items[0].value;
                    pending_items.pop_front();
                end
            end
        end
    end

    // Response side: checks each answer beat and stalls at random between beats.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall_left = 0;
        end
        else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                answer.found      = rsp_ch.found;
                answer.last_index = rsp_ch.last_index;
                if (pending_answers.size() == 0) begin
                    error_count++;
                    $display("%0t: answer beat with none pending: found=%0d last_index=%0d",
                             $time, answer.found, answer.last_index);
                end
                else begin
                    want = pending_answers.pop_front();
                    if (answer.found !== want.found) begin
                        error_count++;
                        $display("%0t: found mismatch: expected %0d, actual %0d",
                                 $time, want.found, answer.found);
                    end
                    if (answer.last_index !== want.last_index) begin
                        error_count++;
                        $display("%0t: last_index mismatch: expected %0d, actual %0d",
                                 $time, want.last_index, answer.last_index);
                    end
                    if (want.found)
                        hits_seen++;
                end
                if ($urandom_range(0, 49) == 0)
                    rsp_calm = !rsp_calm;
                rsp_stall_left = rsp_calm ? 0 : $urandom_range(0, 7);
            end
            if (rsp_stall_left > 0) begin
                rsp_stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus, drain and verdict.
    initial begin
        int i;
        int pick;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_CLEAR;
        req_ch.value     = '0;
        rsp_ch.ready     = 1'b0;
        mirror_count     = 0;
        stim_count       = 0;
        error_count      = 0;
        clears_seen      = 0;
        appends_seen     = 0;
        searches_seen    = 0;
        hits_seen        = 0;
        deepest_fill     = 0;
        req_calm         = 1'b0;
        rsp_calm         = 1'b0;

        // Directed: empty table, extremes with duplicates, misses, unused code.
        queue_beat(OP_SEARCH, 32'sd0);
        queue_beat(OP_APPEND, VAL_MIN);
        queue_beat(OP_APPEND, VAL_MIN);
        queue_beat(OP_APPEND, -32'sd1);
        queue_beat(OP_APPEND, 32'sd0);
        queue_beat(OP_APPEND, 32'sd0);
        queue_beat(OP_APPEND, 32'sd0);
        queue_beat(OP_APPEND, 32'sd1);
        queue_beat(OP_APPEND, VAL_MAX);
        queue_beat(OP_SEARCH, VAL_MIN);
        queue_beat(OP_SEARCH, 32'sd0);
        queue_beat(OP_SEARCH, VAL_MAX);
        queue_beat(OP_SEARCH, -32'sd1);
        queue_beat(OP_SEARCH, 32'sd5);
        queue_beat(OP_SEARCH, -32'sd2);
        queue_beat(OP_UNUSED, 32'sd7);
        queue_beat(OP_SEARCH, 32'sd1);
        queue_beat(OP_CLEAR, VAL_MAX);
        queue_beat(OP_SEARCH, 32'sd0);
        queue_beat(OP_APPEND, 32'sd42);
        queue_beat(OP_SEARCH, 32'sd42);
        queue_beat(OP_SEARCH, 32'sd41);
        queue_beat(OP_SEARCH, 32'sd43);
        // An unsorted table still runs the same probe sequence.
        queue_beat(OP_APPEND, 32'sd3);
        queue_beat(OP_SEARCH, 32'sd3);

        // Full table: appends past the end are dropped, indexes reach the top.
        queue_beat(OP_CLEAR, '0);
        phase_vals.delete();
        for (i = 0; i < TABLE_DEPTH; i++) begin
            if (i == TABLE_DEPTH - 1)
                phase_vals.push_back(VAL_MAX);
            else
                phase_vals.push_back(VAL_MIN + (i / 2) * 32'sd8388608);
            queue_beat(OP_APPEND, phase_vals[i]);
        end
        queue_beat(OP_APPEND, 32'sd5);
        queue_beat(OP_APPEND, VAL_MIN);
        queue_beat(OP_APPEND, VAL_MAX);
        queue_beat(OP_SEARCH, VAL_MAX);
        queue_beat(OP_SEARCH, VAL_MIN);
        queue_beat(OP_SEARCH, VAL_MIN + 32'sd1);
        queue_beat(OP_SEARCH, 32'sd5);
        repeat (24)
            queue_beat(OP_SEARCH, pick_key());

        // Random runs: mostly sorted tables of small size, some unsorted ones and noise.
        stim_count = 0;
        while (stim_count < RANDOM_BEATS) begin
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                if ($urandom_range(0, 3) == 0)
                    build_sorted_run($urandom_range(0, 64));
                else
                    build_sorted_run($urandom_range(1, 12));
            end
            else if (pick == 7) begin
                queue_beat(OP_CLEAR, $urandom);
                phase_vals.delete();
                repeat ($urandom_range(0, 16)) begin
                    if ($urandom_range(0, 1) == 0)
                        phase_vals.push_back($urandom);
                    else
                        phase_vals.push_back(int'($urandom_range(0, 6)) - 3);
                    queue_beat(OP_APPEND, phase_vals[$]);
                end
                repeat ($urandom_range(1, 5))
                    queue_beat(OP_SEARCH, pick_key());
            end
            else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 3))
                        0:       queue_beat(OP_CLEAR, $urandom);
                        1:       queue_beat(OP_APPEND, $urandom);
                        2:       queue_beat(OP_SEARCH, pick_key());
                        default: queue_beat(OP_UNUSED, $urandom);
                    endcase
                end
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every beat to go out and every answer to come back.
        while (pending_items.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_answers.size() != 0) begin
            error_count++;
            $display("%0t: %0d answers never arrived", $time, pending_answers.size());
        end
        $display("Sent %0d clears, %0d appends and %0d searches (%0d hits);",
                 clears_seen, appends_seen, searches_seen, hits_seen);
        $display("table fill reached %0d entries, %0d errors.", deepest_fill, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/bsl_pkg.sv
src/bsl_req_if.sv
src/bsl_rsp_if.sv
src/bsl_table.sv
src/bsl_engine.sv
src/binary_search_last_occurrence.sv
tb/sv/binary_search_last_occurrence_test.sv
